// ----- rtl/core/csx_pkg.sv -----
package csx_pkg;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam int unsigned CFG_AW = 3;
  localparam int unsigned CFG_DW = 64;

  localparam logic [CFG_AW-1:0] REG_KEY_A    = 3'd0;
  localparam logic [CFG_AW-1:0] REG_KEY_B    = 3'd1;
  localparam logic [CFG_AW-1:0] REG_KEY_C    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_KEY_D    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_NONCE_LO = 3'd4;
  localparam logic [CFG_AW-1:0] REG_NONCE_HI = 3'd5;
  localparam logic [CFG_AW-1:0] REG_START    = 3'd6;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // copy input state into working words, start block
    logic round;      // run one half round (column or diagonal)
    logic diag;       // select diagonal half round
    logic finish;     // add input state back, fill keystream buffer
    logic take;       // consume one byte: capture output, advance position
    logic restart;    // reset position and counter to configured start
  } csx_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic pos_zero;   // no keystream block made for this position yet: a new block is needed
  } csx_sts_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int unsigned n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // One full ChaCha quarter round on four words
  function automatic logic [127:0] qr(input logic [31:0] a, input logic [31:0] b,
                                      input logic [31:0] c, input logic [31:0] d);
    logic [31:0] a1, b1, c1, d1;
    a1 = a + b;   d1 = rotl(d ^ a1, 16);
    c1 = c + d1;  b1 = rotl(b ^ c1, 12);
    a1 = a1 + b1; d1 = rotl(d1 ^ a1, 8);
    c1 = c1 + d1; b1 = rotl(b1 ^ c1, 7);
    qr = {a1, b1, c1, d1};
  endfunction

endpackage

// ----- rtl/core/chacha20_stream_xor_core.sv -----
// Block start: a byte at the start of a 64-byte block waits for keystream
//   generation: a load, 2*DOUBLE_ROUNDS half rounds, then a finish step.
// Other bytes: out_valid rises in the cycle after accept; one byte per cycle while out_ready holds.
// Block generation: the half-round logic does four quarter rounds per cycle; no byte
//   is accepted while a new block is being made.
// Reset: synchronous active-low; configuration registers clear, position and counter go to zero.
module chacha20_stream_xor_core #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [csx_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [csx_pkg::CFG_DW-1:0] cfg_wdata,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_last_byte,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [7:0]                 out_byte,
  output logic                       out_last
);

  csx_pkg::csx_cmd_t cmd;
  csx_pkg::csx_sts_t sts;

  csx_ctrl #(.DOUBLE_ROUNDS(DOUBLE_ROUNDS)) u_ctrl (
    .clk, .rst_n, .cfg_we, .in_valid, .in_ready, .in_last_byte,
    .out_valid, .out_ready, .sts, .cmd
  );

  csx_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_addr, .cfg_wdata, .in_data_byte, .in_last_byte,
    .out_byte, .out_last, .cmd, .sts
  );

endmodule

// ----- rtl/core/csx_ctrl.sv -----
module csx_ctrl #(
  parameter int unsigned DOUBLE_ROUNDS = 10
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_last_byte,
  output logic              out_valid,
  input  logic              out_ready,
  input  csx_pkg::csx_sts_t sts,
  output csx_pkg::csx_cmd_t cmd
);

  localparam int unsigned HALF_ROUNDS = 2 * DOUBLE_ROUNDS;
  localparam int unsigned HW = $clog2(HALF_ROUNDS);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ROUND = 3'b010,
    ST_FIN   = 3'b100
  } state_t;

  state_t        state_r, state_nxt;
  logic [HW-1:0] half_r, half_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          accept;

  // Accept a byte only with a ready keystream and room at the output
  assign in_ready  = (state_r == ST_IDLE) && !sts.pos_zero && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    half_nxt      = half_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        if (cfg_we) begin
          cmd.restart = 1'b1;
        end else if (accept) begin
          cmd.take      = 1'b1;
          cmd.restart   = in_last_byte;
          out_valid_nxt = 1'b1;
        end else if (sts.pos_zero && in_valid) begin
          cmd.load  = 1'b1;
          half_nxt  = '0;
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd.round = 1'b1;
        cmd.diag  = half_r[0];
        half_nxt  = half_r + 1'b1;
        if (half_r == HW'(HALF_ROUNDS - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      half_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      half_r      <= half_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef ASSERT_OFF
  a_no_take_in_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !cmd.take)
    else $error("byte taken during block generation");
  a_fin_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |-> $past(state_r == ST_ROUND))
    else $error("finish without rounds");
  a_out_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |=> out_valid_r)
    else $error("taken byte not presented");
`endif

endmodule

// ----- rtl/core/csx_dp.sv -----
module csx_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [csx_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [csx_pkg::CFG_DW-1:0]  cfg_wdata,
  input  logic [7:0]                  in_data_byte,
  input  logic                        in_last_byte,
  output logic [7:0]                  out_byte,
  output logic                        out_last,
  input  csx_pkg::csx_cmd_t           cmd,
  output csx_pkg::csx_sts_t           sts
);

  logic [255:0] key_r;
  logic [95:0]  nonce_r;
  logic [31:0]  start_r;
  logic [31:0]  count_r, count_nxt;
  logic [5:0]   pos_r, pos_nxt;
  logic [31:0]  w_r [16];
  logic [31:0]  init_w [16];
  logic [31:0]  w_nxt [16];
  logic [7:0]   byte_r;
  logic         last_r;
  logic         cfg_hit;

  assign cfg_hit = cfg_we && (cfg_addr <= csx_pkg::REG_START);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r   <= '0;
      nonce_r <= '0;
      start_r <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        csx_pkg::REG_KEY_A:    key_r[63:0]    <= cfg_wdata;
        csx_pkg::REG_KEY_B:    key_r[127:64]  <= cfg_wdata;
        csx_pkg::REG_KEY_C:    key_r[191:128] <= cfg_wdata;
        csx_pkg::REG_KEY_D:    key_r[255:192] <= cfg_wdata;
        csx_pkg::REG_NONCE_LO: nonce_r[63:0]  <= cfg_wdata;
        csx_pkg::REG_NONCE_HI: nonce_r[95:64] <= cfg_wdata[31:0];
        csx_pkg::REG_START:    start_r        <= cfg_wdata[31:0];
        default: ;
      endcase
    end
  end

  // Build the block input state
  always_comb begin
    init_w[0] = csx_pkg::SIGMA0;
    init_w[1] = csx_pkg::SIGMA1;
    init_w[2] = csx_pkg::SIGMA2;
    init_w[3] = csx_pkg::SIGMA3;
    for (int i = 0; i < 8; i++) begin
      init_w[4+i] = key_r[32*i +: 32];
    end
    init_w[12] = count_r;
    init_w[13] = nonce_r[31:0];
    init_w[14] = nonce_r[63:32];
    init_w[15] = nonce_r[95:64];
  end

  // One half round: four independent quarter rounds
  always_comb begin
    for (int i = 0; i < 16; i++) w_nxt[i] = w_r[i];
    if (!cmd.diag) begin
      for (int i = 0; i < 4; i++) begin
        {w_nxt[i], w_nxt[4+i], w_nxt[8+i], w_nxt[12+i]} =
          csx_pkg::qr(w_r[i], w_r[4+i], w_r[8+i], w_r[12+i]);
      end
    end else begin
      {w_nxt[0], w_nxt[5], w_nxt[10], w_nxt[15]} = csx_pkg::qr(w_r[0], w_r[5], w_r[10], w_r[15]);
      {w_nxt[1], w_nxt[6], w_nxt[11], w_nxt[12]} = csx_pkg::qr(w_r[1], w_r[6], w_r[11], w_r[12]);
      {w_nxt[2], w_nxt[7], w_nxt[8], w_nxt[13]}  = csx_pkg::qr(w_r[2], w_r[7], w_r[8], w_r[13]);
      {w_nxt[3], w_nxt[4], w_nxt[9], w_nxt[14]}  = csx_pkg::qr(w_r[3], w_r[4], w_r[9], w_r[14]);
    end
  end

  // Working words; after the finish step they hold the keystream block in place
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 16; i++) w_r[i] <= init_w[i];
    end else if (cmd.round) begin
      for (int i = 0; i < 16; i++) w_r[i] <= w_nxt[i];
    end else if (cmd.finish) begin
      for (int i = 0; i < 16; i++) w_r[i] <= w_r[i] + init_w[i];
    end
  end

  // Advance position and counter
  always_comb begin
    pos_nxt   = pos_r;
    count_nxt = count_r;
    if (cmd.take) begin
      pos_nxt = pos_r + 6'd1;
      if (pos_r == 6'd63) count_nxt = count_r + 32'd1;
    end
    if ((cmd.restart && !cfg_we) || cfg_hit) begin
      pos_nxt   = '0;
      count_nxt = (cfg_we && cfg_addr == csx_pkg::REG_START) ? cfg_wdata[31:0] : start_r;
    end
  end

  // pos_zero must mean "block not yet made": track with a fresh flag
  logic fresh_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      count_r <= '0;
      fresh_r <= 1'b1;
    end else begin
      pos_r   <= pos_nxt;
      count_r <= count_nxt;
      if (cmd.finish) fresh_r <= 1'b0;
      else if (pos_nxt == 6'd0 && (cmd.take || cmd.restart || cfg_hit)) fresh_r <= 1'b1;
    end
  end
  assign sts.pos_zero = fresh_r;

  // Output register: pick the keystream byte little-endian from its word
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      byte_r <= in_data_byte ^ w_r[pos_r[5:2]][{pos_r[1:0], 3'b000} +: 8];
      last_r <= in_last_byte;
    end
  end
  assign out_byte = byte_r;
  assign out_last = last_r;

`ifndef ASSERT_OFF
  a_take_needs_block: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take |-> !fresh_r)
    else $error("byte taken without keystream");
  a_wrap_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take && pos_r == 6'd63 && !cmd.restart && !cfg_we) |=> (pos_r == 6'd0 && fresh_r))
    else $error("block end not handled");
  a_restart_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (pos_r == 6'd0))
    else $error("config write did not restart");
`endif

endmodule
